// File: rtl/core/rrdwd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Round robin domain dispatcher package
// Field widths, limits, command and error codes shared by the dispatcher files.
// -----------------------------------------------------------------------------
package rrdwd_pkg;

  localparam int unsigned TableDepthDef = 8;
  localparam int unsigned IdBitsDef     = 16;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned IdW    = 16;
  localparam int unsigned WorkW  = 15;
  localparam int unsigned PendW  = 16;
  localparam int unsigned RunW   = 15;
  localparam int unsigned StartW = 5;
  localparam int unsigned ErrW   = 2;

  localparam logic [StartW-1:0] StartLimit    = 5'd16;
  localparam logic [WorkW-1:0]  WorkLimit     = 15'h7FFF;
  localparam logic [PendW-1:0]  PendLimit     = 16'hFFFF;
  localparam logic [RunW-1:0]   RunLimit      = 15'h7FFF;
  localparam logic [WorkW-1:0]  MaxWorkersRst = 15'd8;

  typedef enum logic [CmdW-1:0] {
    CmdRequest     = 3'd0,
    CmdWorkerStart = 3'd1,
    CmdFetch       = 3'd2,
    CmdJobDone     = 3'd3,
    CmdWorkerExit  = 3'd4,
    CmdRemove      = 3'd5
  } cmd_e;

  typedef enum logic [ErrW-1:0] {
    ErrNone      = 2'd0,
    ErrFull      = 2'd1,
    ErrUnderflow = 2'd2,
    ErrOverflow  = 2'd3
  } err_e;

  typedef struct packed {
    logic             accepted;
    logic             wake_worker;
    logic [IdW-1:0]   grant_domain;
    logic             entry_removed;
    logic             was_busy;
    logic [WorkW-1:0] available_workers;
    err_e             error_code;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/core/rrdwd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Dispatcher command channel
// Valid/ready channel that carries one command beat into the dispatcher.
// -----------------------------------------------------------------------------
interface rrdwd_in_if;
  import rrdwd_pkg::*;

  logic            valid;
  logic            ready;
  logic [CmdW-1:0] command;
  logic [IdW-1:0]  domain_id;
  logic [IdW-1:0]  prev_domain;
  logic            prev_valid;
  logic            unloading;

  modport source (output valid, output command, output domain_id, output prev_domain,
                  output prev_valid, output unloading, input ready);
  modport sink   (input valid, input command, input domain_id, input prev_domain,
                  input prev_valid, input unloading, output ready);
endinterface
`default_nettype wire

// File: rtl/core/rrdwd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Dispatcher result channel
// Valid/ready channel that carries one result beat out of the dispatcher.
// -----------------------------------------------------------------------------
interface rrdwd_out_if;
  import rrdwd_pkg::*;

  logic             valid;
  logic             ready;
  logic             accepted;
  logic             wake_worker;
  logic [IdW-1:0]   grant_domain;
  logic             entry_removed;
  logic             was_busy;
  logic [WorkW-1:0] available_workers;
  logic [ErrW-1:0]  error_code;

  modport source (output valid, output accepted, output wake_worker, output grant_domain,
                  output entry_removed, output was_busy, output available_workers,
                  output error_code, input ready);
  modport sink   (input valid, input accepted, input wake_worker, input grant_domain,
                  input entry_removed, input was_busy, input available_workers,
                  input error_code, output ready);
endinterface
`default_nettype wire

// File: rtl/core/round_robin_domain_work_dispatcher.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Round robin domain work dispatcher
// Ordered table of requester domains with pending and running job counts.
// -----------------------------------------------------------------------------
// The dispatcher takes one command beat at a time and answers each with exactly
// one result beat. The domain table has one read and one write address, and a
// small sequencer walks it one entry per cycle: a lookup of the named domain, a
// step to act, then either a round robin scan for pending work or a shift of
// later entries after a removal, and a step that hands the result to the output
// register, which waits while that register still holds a result not yet taken.
// The command channel is ready again once the result has moved into the output
// register, even while that result still waits to be taken.
// max_workers may only be written while no command is in flight.
module round_robin_domain_work_dispatcher #(
  parameter int unsigned TABLE_DEPTH = rrdwd_pkg::TableDepthDef,
  parameter int unsigned ID_BITS     = rrdwd_pkg::IdBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rrdwd_pkg::WorkW-1:0] cfg_wdata_i,
  rrdwd_in_if.sink                    req_i,
  rrdwd_out_if.source                 rsp_o
);
  import rrdwd_pkg::*;

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] Depth = CntW'(TABLE_DEPTH);
  localparam logic [IdW-1:0] IdMask =
      (ID_BITS >= IdW) ? {IdW{1'b1}} : IdW'((64'd1 << ID_BITS) - 64'd1);

  typedef enum logic [2:0] {
    StIdle,
    StFind,
    StAct,
    StScan,
    StShift,
    StDone
  } state_e;

  state_e            state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  logic [IdW-1:0]    dom_q, dom_d;
  logic [IdW-1:0]    prev_q, prev_d;
  logic              prev_ok_q, prev_ok_d;
  logic              unl_q, unl_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   ptr_q, ptr_d;
  logic [IdxW-1:0]   hit_q, hit_d;
  logic              found_q, found_d;
  result_t           res_q, res_d;
  result_t           out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [CntW-1:0]   slot_count_q, slot_count_d;
  logic [StartW-1:0] starting_q, starting_d;
  logic [WorkW-1:0]  working_q, working_d;
  logic [WorkW-1:0]  max_workers_q, max_workers_d;

  // Domain table: one read and one write address per cycle.
  logic [IdW-1:0]   slot_domain_q  [TABLE_DEPTH];
  logic [PendW-1:0] slot_pending_q [TABLE_DEPTH];
  logic [RunW-1:0]  slot_running_q [TABLE_DEPTH];

  logic [IdxW-1:0]  rd_idx;
  logic [IdW-1:0]   rd_dom;
  logic [PendW-1:0] rd_pend;
  logic [RunW-1:0]  rd_run;
  logic             wr_en;
  logic [IdxW-1:0]  wr_idx;
  logic [IdW-1:0]   wr_dom;
  logic [PendW-1:0] wr_pend;
  logic [RunW-1:0]  wr_run;

  logic [CntW-1:0]  ptr_inc;
  logic [CntW-1:0]  scan_start;
  logic [IdW-1:0]   find_key;
  logic             need_find;
  logic [WorkW-1:0] avail;

  assign ptr_inc    = ptr_q + 1'b1;
  assign scan_start = found_q ? (CntW'(hit_q) + 1'b1) : '0;
  assign find_key   = (cmd_q == CmdFetch) ? prev_q : dom_q;
  assign need_find  = (cmd_q == CmdRequest) || (cmd_q == CmdJobDone) ||
                      (cmd_q == CmdRemove) || ((cmd_q == CmdFetch) && prev_ok_q);
  assign avail      = (max_workers_q > working_q) ? (max_workers_q - working_q) : '0;

  always_comb begin
    case (state_q)
      StFind:  rd_idx = cnt_q[IdxW-1:0];
      StAct:   rd_idx = hit_q;
      StScan:  rd_idx = ptr_q[IdxW-1:0];
      StShift: rd_idx = ptr_inc[IdxW-1:0];
      default: rd_idx = cnt_q[IdxW-1:0];
    endcase
  end

  assign rd_dom  = slot_domain_q[rd_idx];
  assign rd_pend = slot_pending_q[rd_idx];
  assign rd_run  = slot_running_q[rd_idx];

  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    dom_d         = dom_q;
    prev_d        = prev_q;
    prev_ok_d     = prev_ok_q;
    unl_d         = unl_q;
    cnt_d         = cnt_q;
    ptr_d         = ptr_q;
    hit_d         = hit_q;
    found_d       = found_q;
    res_d         = res_q;
    out_d         = out_q;
    slot_count_d  = slot_count_q;
    starting_d    = starting_q;
    working_d     = working_q;
    max_workers_d = cfg_we_i ? cfg_wdata_i : max_workers_q;
    out_valid_d   = out_valid_q && !rsp_o.ready;
    wr_en         = 1'b0;
    wr_idx        = rd_idx;
    wr_dom        = rd_dom;
    wr_pend       = rd_pend;
    wr_run        = rd_run;

    case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          cmd_d     = cmd_e'(req_i.command);
          dom_d     = req_i.domain_id & IdMask;
          prev_d    = req_i.prev_domain & IdMask;
          prev_ok_d = req_i.prev_valid;
          unl_d     = req_i.unloading;
          cnt_d     = '0;
          found_d   = 1'b0;
          res_d     = '0;
          state_d   = StFind;
        end
      end

      StFind: begin
        if (!need_find || (cnt_q == slot_count_q)) begin
          state_d = StAct;
        end else if (rd_dom == find_key) begin
          found_d = 1'b1;
          hit_d   = cnt_q[IdxW-1:0];
          state_d = StAct;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      StAct: begin
        state_d = StDone;
        case (cmd_q)
          CmdRequest: begin
            if (!unl_q) begin
              if (!found_q && (slot_count_q >= Depth)) begin
                res_d.error_code = ErrFull;
              end else begin
                wr_en = 1'b1;
                if (found_q) begin
                  wr_idx  = hit_q;
                  wr_pend = (rd_pend != PendLimit) ? (rd_pend + 1'b1) : rd_pend;
                end else begin
                  wr_idx       = slot_count_q[IdxW-1:0];
                  wr_dom       = dom_q;
                  wr_pend      = PendW'(1);
                  wr_run       = '0;
                  slot_count_d = slot_count_q + 1'b1;
                end
                res_d.accepted = 1'b1;
                if (starting_q != StartLimit) begin
                  starting_d        = starting_q + 1'b1;
                  res_d.wake_worker = 1'b1;
                end
              end
            end
          end
          CmdWorkerStart: begin
            if (working_q == WorkLimit) begin
              res_d.error_code = ErrOverflow;
            end else if (starting_q == '0) begin
              res_d.error_code = ErrUnderflow;
            end else begin
              starting_d = starting_q - 1'b1;
              working_d  = working_q + 1'b1;
            end
          end
          CmdWorkerExit: begin
            if (working_q == '0) begin
              res_d.error_code = ErrUnderflow;
            end else begin
              working_d = working_q - 1'b1;
            end
          end
          CmdJobDone: begin
            if (!found_q || (rd_run == '0)) begin
              res_d.error_code = ErrUnderflow;
            end else begin
              wr_en  = 1'b1;
              wr_idx = hit_q;
              wr_run = rd_run - 1'b1;
              // The entry goes idle while its domain unloads: drop it.
              if ((rd_pend == '0) && (rd_run == RunW'(1)) && unl_q) begin
                res_d.entry_removed = 1'b1;
                ptr_d               = CntW'(hit_q);
                state_d             = StShift;
              end
            end
          end
          CmdRemove: begin
            if (found_q) begin
              res_d.was_busy      = (rd_pend != '0) || (rd_run != '0);
              res_d.entry_removed = 1'b1;
              ptr_d               = CntW'(hit_q);
              state_d             = StShift;
            end
          end
          CmdFetch: begin
            if (slot_count_q != '0) begin
              // Start just after the previous domain, wrapping past the end.
              ptr_d   = (scan_start == slot_count_q) ? '0 : scan_start;
              cnt_d   = '0;
              state_d = StScan;
            end
          end
          default: begin
          end
        endcase
      end

      StScan: begin
        if (cnt_q == slot_count_q) begin
          state_d = StDone;
        end else if (rd_pend != '0) begin
          wr_en              = 1'b1;
          wr_idx             = ptr_q[IdxW-1:0];
          wr_pend            = rd_pend - 1'b1;
          wr_run             = (rd_run != RunLimit) ? (rd_run + 1'b1) : rd_run;
          res_d.accepted     = 1'b1;
          res_d.grant_domain = rd_dom;
          state_d            = StDone;
        end else begin
          cnt_d = cnt_q + 1'b1;
          ptr_d = (ptr_inc == slot_count_q) ? '0 : ptr_inc;
        end
      end

      StShift: begin
        if (ptr_inc < slot_count_q) begin
          wr_en  = 1'b1;
          wr_idx = ptr_q[IdxW-1:0];
          ptr_d  = ptr_inc;
        end else begin
          slot_count_d = slot_count_q - 1'b1;
          state_d      = StDone;
        end
      end

      StDone: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d                   = res_q;
          out_d.available_workers = avail;
          out_valid_d             = 1'b1;
          state_d                 = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      cmd_q         <= CmdRequest;
      dom_q         <= '0;
      prev_q        <= '0;
      prev_ok_q     <= 1'b0;
      unl_q         <= 1'b0;
      cnt_q         <= '0;
      ptr_q         <= '0;
      hit_q         <= '0;
      found_q       <= 1'b0;
      res_q         <= '0;
      out_q         <= '0;
      out_valid_q   <= 1'b0;
      slot_count_q  <= '0;
      starting_q    <= '0;
      working_q     <= '0;
      max_workers_q <= MaxWorkersRst;
    end else begin
      state_q       <= state_d;
      cmd_q         <= cmd_d;
      dom_q         <= dom_d;
      prev_q        <= prev_d;
      prev_ok_q     <= prev_ok_d;
      unl_q         <= unl_d;
      cnt_q         <= cnt_d;
      ptr_q         <= ptr_d;
      hit_q         <= hit_d;
      found_q       <= found_d;
      res_q         <= res_d;
      out_q         <= out_d;
      out_valid_q   <= out_valid_d;
      slot_count_q  <= slot_count_d;
      starting_q    <= starting_d;
      working_q     <= working_d;
      max_workers_q <= max_workers_d;
    end
  end

  // Entries at or above slot_count are never used, so the table needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_domain_q[wr_idx]  <= wr_dom;
      slot_pending_q[wr_idx] <= wr_pend;
      slot_running_q[wr_idx] <= wr_run;
    end
  end

  assign req_i.ready             = (state_q == StIdle);
  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.accepted          = out_q.accepted;
  assign rsp_o.wake_worker       = out_q.wake_worker;
  assign rsp_o.grant_domain      = out_q.grant_domain;
  assign rsp_o.entry_removed     = out_q.entry_removed;
  assign rsp_o.was_busy          = out_q.was_busy;
  assign rsp_o.available_workers = out_q.available_workers;
  assign rsp_o.error_code        = out_q.error_code;

endmodule
`default_nettype wire

// File: rtl/core/rrdwd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Dispatcher port checker
// Assertions on the dispatcher's channels, bound to the top level.
// -----------------------------------------------------------------------------
module rrdwd_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic                        accepted_i,
  input wire logic                        wake_worker_i,
  input wire logic [rrdwd_pkg::IdW-1:0]   grant_domain_i,
  input wire logic                        entry_removed_i,
  input wire logic                        was_busy_i,
  input wire logic [rrdwd_pkg::WorkW-1:0] available_workers_i,
  input wire logic [rrdwd_pkg::ErrW-1:0]  error_code_i
);
  import rrdwd_pkg::*;

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable({accepted_i, wake_worker_i, grant_domain_i,
      entry_removed_i, was_busy_i, available_workers_i, error_code_i}))
    else $error("stalled result beat changed");

  // The dispatcher works on one command at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second command taken while one is in flight");

  a_wake_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && wake_worker_i |-> accepted_i)
    else $error("worker wake without an accepted request");

  // A failing command leaves no trace besides its error code.
  a_error_is_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (error_code_i != ErrNone) |->
      !accepted_i && !wake_worker_i && !entry_removed_i && !was_busy_i &&
      (grant_domain_i == '0))
    else $error("error result carries side effects");

endmodule

bind round_robin_domain_work_dispatcher rrdwd_checker u_rrdwd_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (req_i.valid),
  .in_ready_i          (req_i.ready),
  .out_valid_i         (rsp_o.valid),
  .out_ready_i         (rsp_o.ready),
  .accepted_i          (rsp_o.accepted),
  .wake_worker_i       (rsp_o.wake_worker),
  .grant_domain_i      (rsp_o.grant_domain),
  .entry_removed_i     (rsp_o.entry_removed),
  .was_busy_i          (rsp_o.was_busy),
  .available_workers_i (rsp_o.available_workers),
  .error_code_i        (rsp_o.error_code)
);
`default_nettype wire

// File: bench/dispatch_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Dispatcher result checker
// Watches the command and result channels and the max_workers write port. It
// keeps its own copy of the domain table and worker counts to work out the
// result of each command beat. It then compares every result beat, field by
// field, with the oldest outstanding prediction.
// -----------------------------------------------------------------------------
module dispatch_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rrdwd_pkg::WorkW-1:0] cfg_wdata_i,
  rrdwd_in_if                         cmd_i,
  rrdwd_out_if                        rsp_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 checked_o,
  output int unsigned                 backlog_o
);
  import rrdwd_pkg::*;

  localparam int unsigned Depth = TableDepthDef;

  logic [IdW-1:0]    tbl_dom  [Depth];
  logic [PendW-1:0]  tbl_pend [Depth];
  logic [RunW-1:0]   tbl_run  [Depth];
  int unsigned       tbl_len;
  logic [StartW-1:0] starting;
  logic [WorkW-1:0]  working;
  logic [WorkW-1:0]  max_workers;
  result_t           owed_results_q[$];

  function automatic int find_entry(input logic [IdW-1:0] id);
    for (int i = 0; i < int'(tbl_len); i++) begin
      if (tbl_dom[i] == id) return i;
    end
    return -1;
  endfunction

  // Later entries move down one place so the table keeps its order.
  function automatic void drop_entry(input int idx);
    for (int i = idx; i + 1 < int'(tbl_len); i++) begin
      tbl_dom[i]  = tbl_dom[i + 1];
      tbl_pend[i] = tbl_pend[i + 1];
      tbl_run[i]  = tbl_run[i + 1];
    end
    tbl_len--;
    tbl_dom[tbl_len]  = '0;
    tbl_pend[tbl_len] = '0;
    tbl_run[tbl_len]  = '0;
  endfunction

  function automatic result_t predict_dispatch(input logic [CmdW-1:0] c,
                                               input logic [IdW-1:0]  dom,
                                               input logic [IdW-1:0]  prev,
                                               input logic            prev_ok,
                                               input logic            unl);
    result_t     r;
    int          s;
    int unsigned first;
    int unsigned idx;
    r = '0;
    r.error_code = ErrNone;
    case (c)
      CmdRequest: begin
        if (!unl) begin
          s = find_entry(dom);
          if (s < 0 && tbl_len >= Depth) begin
            r.error_code = ErrFull;
          end else begin
            if (s < 0) begin
              s = int'(tbl_len);
              tbl_dom[s]  = dom;
              tbl_pend[s] = '0;
              tbl_run[s]  = '0;
              tbl_len++;
            end
            if (tbl_pend[s] != PendLimit) tbl_pend[s]++;
            r.accepted = 1'b1;
            if (starting != StartLimit) begin
              starting++;
              r.wake_worker = 1'b1;
            end
          end
        end
      end
      CmdWorkerStart: begin
        if (working == WorkLimit) begin
          r.error_code = ErrOverflow;
        end else if (starting == '0) begin
          r.error_code = ErrUnderflow;
        end else begin
          starting--;
          working++;
        end
      end
      CmdFetch: begin
        first = 0;
        if (prev_ok) begin
          s = find_entry(prev);
          if (s >= 0) first = s + 1;
        end
        for (int unsigned k = 0; k < tbl_len; k++) begin
          idx = (first + k) % tbl_len;
          if (!r.accepted && tbl_pend[idx] != '0) begin
            tbl_pend[idx]--;
            if (tbl_run[idx] != RunLimit) tbl_run[idx]++;
            r.accepted     = 1'b1;
            r.grant_domain = tbl_dom[idx];
          end
        end
      end
      CmdJobDone: begin
        s = find_entry(dom);
        if (s < 0) begin
          r.error_code = ErrUnderflow;
        end else if (tbl_run[s] == '0) begin
          r.error_code = ErrUnderflow;
        end else begin
          tbl_run[s]--;
          if (tbl_pend[s] == '0 && tbl_run[s] == '0 && unl) begin
            drop_entry(s);
            r.entry_removed = 1'b1;
          end
        end
      end
      CmdWorkerExit: begin
        if (working == '0) r.error_code = ErrUnderflow;
        else working--;
      end
      CmdRemove: begin
        s = find_entry(dom);
        if (s >= 0) begin
          r.was_busy      = (tbl_pend[s] != '0) || (tbl_run[s] != '0);
          r.entry_removed = 1'b1;
          drop_entry(s);
        end
      end
      default: ;
    endcase
    r.available_workers = (max_workers > working) ? max_workers - working : '0;
    return r;
  endfunction

  function automatic int unsigned field_diff(input string       name,
                                             input logic [31:0] want,
                                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    result_t     want;
    int unsigned miss;
    if (!rst_ni) begin
      foreach (tbl_dom[i]) begin
        tbl_dom[i]  = '0;
        tbl_pend[i] = '0;
        tbl_run[i]  = '0;
      end
      tbl_len      = 0;
      starting     = '0;
      working      = '0;
      max_workers  = MaxWorkersRst;
      owed_results_q.delete();
      fail_count_o = 0;
      checked_o    = 0;
      backlog_o    = 0;
    end else begin
      if (cfg_we_i) max_workers = cfg_wdata_i;
      if (rsp_i.valid && rsp_i.ready) begin
        checked_o++;
        if (owed_results_q.size() == 0) begin
          $display("%0t ns: result beat arrived with no command outstanding", $time);
          fail_count_o++;
        end else begin
          want = owed_results_q.pop_front();
          miss = 0;
          miss += field_diff("accepted", want.accepted, rsp_i.accepted);
          miss += field_diff("wake_worker", want.wake_worker, rsp_i.wake_worker);
          miss += field_diff("grant_domain", want.grant_domain, rsp_i.grant_domain);
          miss += field_diff("entry_removed", want.entry_removed, rsp_i.entry_removed);
          miss += field_diff("was_busy", want.was_busy, rsp_i.was_busy);
          miss += field_diff("available_workers", want.available_workers,
                             rsp_i.available_workers);
          miss += field_diff("error_code", want.error_code, rsp_i.error_code);
          fail_count_o += miss;
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        owed_results_q.push_back(predict_dispatch(cmd_i.command, cmd_i.domain_id,
                                                  cmd_i.prev_domain, cmd_i.prev_valid,
                                                  cmd_i.unloading));
      end
      backlog_o = owed_results_q.size();
    end
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Dispatcher testbench top
// Drives command beats into the dispatcher: a directed opening, random phases
// under several max_workers values, and a burst on one domain that drives the
// starting count to its limit. Result ready stalls at random and once for a
// long stretch. The checker beside the block does all prediction and comparison.
// -----------------------------------------------------------------------------
module tb;
  import rrdwd_pkg::*;

  localparam int          ClkPeriod   = 4;
  localparam int unsigned PoolSize    = 12;
  localparam int unsigned PhaseItems  = 440;
  localparam int unsigned HoldCycles  = 500;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned TailCycles  = 40;
  localparam int unsigned SatRequests = 64;
  localparam int unsigned SatFetches  = 32;

  localparam logic [CmdW-1:0] CmdSpareA = 3'd6;
  localparam logic [CmdW-1:0] CmdSpareB = 3'd7;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [WorkW-1:0] cfg_wdata;

  int unsigned fail_count;
  int unsigned checked;
  int unsigned backlog;
  int unsigned sent_cnt;
  int unsigned setting_cnt;
  bit          idle_on;
  bit          squeeze_req;

  logic [IdW-1:0] dom_pool [PoolSize];

  rrdwd_in_if  cmd_if ();
  rrdwd_out_if rsp_if ();

  round_robin_domain_work_dispatcher dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (cmd_if),
    .rsp_o      (rsp_if)
  );

  dispatch_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .cmd_i       (cmd_if),
    .rsp_i       (rsp_if),
    .fail_count_o(fail_count),
    .checked_o   (checked),
    .backlog_o   (backlog)
  );

  initial clk = 1'b0;
  always #(ClkPeriod / 2) clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [IdW-1:0] pick_domain();
    if ($urandom_range(0, 9) == 0) return IdW'($urandom);
    return dom_pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  function automatic void refill_pool();
    dom_pool[0] = '0;
    dom_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) dom_pool[i] = IdW'($urandom);
  endfunction

  task automatic send_beat(input logic [CmdW-1:0] c,
                           input logic [IdW-1:0]  dom,
                           input logic [IdW-1:0]  prev,
                           input logic            prev_ok,
                           input logic            unl);
    cmd_if.valid       <= 1'b1;
    cmd_if.command     <= c;
    cmd_if.domain_id   <= dom;
    cmd_if.prev_domain <= prev;
    cmd_if.prev_valid  <= prev_ok;
    cmd_if.unloading   <= unl;
    do @(posedge clk); while (!cmd_if.ready);
    sent_cnt++;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // Every command gives one result, so an empty backlog means the block is idle.
  task automatic wait_idle();
    cmd_if.valid <= 1'b0;
    do @(negedge clk); while (backlog != 0);
    @(posedge clk);
  endtask

  task automatic set_max_workers(input logic [WorkW-1:0] value);
    wait_idle();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    setting_cnt++;
  endtask

  task automatic drain_pool();
    foreach (dom_pool[i]) begin
      send_beat(CmdRemove, dom_pool[i], IdW'($urandom), 1'($urandom), 1'($urandom));
    end
  endtask

  task automatic random_phase(input int unsigned n);
    int unsigned     sel;
    logic [CmdW-1:0] c;
    logic [IdW-1:0]  dom;
    logic [IdW-1:0]  prev;
    logic            unl;
    drain_pool();
    refill_pool();
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
      sel  = $urandom_range(0, 99);
      dom  = pick_domain();
      prev = pick_domain();
      unl  = ($urandom_range(0, 3) == 0);
      if (sel < 28) begin
        // Requests only name pool domains so the table can be emptied later.
        c   = CmdRequest;
        dom = dom_pool[$urandom_range(0, PoolSize - 1)];
        unl = ($urandom_range(0, 9) == 0);
      end else if (sel < 43) begin
        c = CmdWorkerStart;
      end else if (sel < 68) begin
        c = CmdFetch;
      end else if (sel < 83) begin
        c   = CmdJobDone;
        unl = ($urandom_range(0, 2) == 0);
      end else if (sel < 90) begin
        c = CmdWorkerExit;
      end else if (sel < 96) begin
        c = CmdRemove;
      end else begin
        c = ($urandom_range(0, 1) == 0) ? CmdSpareA : CmdSpareB;
      end
      send_beat(c, dom, prev, $urandom_range(0, 9) < 7, unl);
    end
  endtask

  // One domain alone in the table takes a burst of requests with only half as
  // many worker starts, so starting reaches its limit and later requests are
  // accepted without a wake. Fetches then move its pending work to running.
  task automatic saturate();
    logic [IdW-1:0] dom;
    drain_pool();
    idle_on = 1'b0;
    dom = dom_pool[2];
    set_max_workers(WorkLimit);
    for (int unsigned n = 0; n < SatRequests; n++) begin
      send_beat(CmdRequest, dom, '0, 1'b0, 1'b0);
      if (n % 2 == 1) send_beat(CmdWorkerStart, dom, '0, 1'b0, 1'b0);
    end
    for (int unsigned n = 0; n < SatFetches; n++) begin
      send_beat(CmdFetch, '0, dom, 1'b1, 1'b0);
    end
    send_beat(CmdWorkerExit, dom, dom, 1'b0, 1'b0);
    send_beat(CmdJobDone, dom, dom, 1'b0, 1'b1);
    send_beat(CmdRemove, dom, dom, 1'b1, 1'b0);
  endtask

  initial begin : result_sink
    bit squeezed;
    squeezed     = 1'b0;
    rsp_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze_req && !squeezed) begin
        // Long hold so the block fills up and stops taking commands.
        squeezed = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t ns: no beat moved for %0d cycles", $time, StallLimit);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    cmd_if.valid       = 1'b0;
    cmd_if.command     = CmdRequest;
    cmd_if.domain_id   = '0;
    cmd_if.prev_domain = '0;
    cmd_if.prev_valid  = 1'b0;
    cmd_if.unloading   = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    rst_n              = 1'b0;
    sent_cnt           = 0;
    setting_cnt        = 0;
    idle_on            = 1'b1;
    squeeze_req        = 1'b0;
    refill_pool();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening with the reset value of max_workers.
    send_beat(CmdWorkerExit, '0, '0, 1'b0, 1'b0);
    send_beat(CmdWorkerStart, '0, '0, 1'b0, 1'b0);
    send_beat(CmdFetch, '0, '0, 1'b0, 1'b0);
    send_beat(CmdJobDone, 16'h1234, '0, 1'b0, 1'b1);
    send_beat(CmdRemove, 16'h1234, '0, 1'b0, 1'b0);
    send_beat(CmdSpareA, '1, '1, 1'b1, 1'b1);
    send_beat(CmdSpareB, '1, '1, 1'b1, 1'b1);
    send_beat(CmdRequest, dom_pool[0], '0, 1'b0, 1'b1);
    send_beat(CmdRequest, dom_pool[0], '0, 1'b0, 1'b0);
    send_beat(CmdRequest, dom_pool[1], '0, 1'b0, 1'b0);
    send_beat(CmdRequest, dom_pool[1], '0, 1'b0, 1'b0);
    send_beat(CmdWorkerStart, '0, '0, 1'b0, 1'b0);
    // Previous domain is the last entry, so the scan wraps to entry zero.
    send_beat(CmdFetch, '0, dom_pool[1], 1'b1, 1'b0);
    // Unknown previous domain: the scan starts at entry zero.
    send_beat(CmdFetch, '0, 16'h1234, 1'b1, 1'b0);
    send_beat(CmdJobDone, dom_pool[0], '0, 1'b0, 1'b1);
    send_beat(CmdJobDone, dom_pool[1], '0, 1'b0, 1'b1);
    send_beat(CmdJobDone, dom_pool[1], '0, 1'b0, 1'b0);
    send_beat(CmdRemove, dom_pool[1], '0, 1'b0, 1'b0);
    for (int i = 0; i <= 8; i++) send_beat(CmdRequest, dom_pool[i], '0, 1'b0, 1'b0);

    set_max_workers(WorkW'(1));
    random_phase(PhaseItems);
    set_max_workers(WorkLimit);
    squeeze_req = 1'b1;
    random_phase(PhaseItems);
    set_max_workers(WorkW'($urandom_range(2, 32766)));
    random_phase(PhaseItems);
    set_max_workers(WorkW'($urandom_range(1, 12)));
    random_phase(PhaseItems);
    saturate();

    wait_idle();
    repeat (TailCycles) @(posedge clk);
    $display("Sent %0d command beats and checked %0d result beats across %0d max_workers values.",
             sent_cnt, checked, setting_cnt + 1);
    $display("Covered error paths, table full, round robin wrap, and the starting limit.");
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
